// ===== rtl/core/xmodem_crc_block_sender_core_assert.svh =====
// ----------------------------------------------------------------------------
// xmodem crc block sender core - assertion macros
// immediate-implication and next-cycle checks on the core's internal logic
// ----------------------------------------------------------------------------
`ifndef XMODEM_CRC_BLOCK_SENDER_CORE_ASSERT_SVH
`define XMODEM_CRC_BLOCK_SENDER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define XCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define XCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/xcs_pkg.sv =====
// ----------------------------------------------------------------------------
// xcs_pkg
// shared types, protocol codes and the crc-16 byte step of the sender core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcs_pkg;

  localparam int BlockBytes = 128;
  localparam int StoreAw    = $clog2(BlockBytes);

  // frame byte positions
  localparam logic [7:0] IdxSoh    = 8'd0;
  localparam logic [7:0] IdxSeq    = 8'd1;
  localparam logic [7:0] IdxSeqInv = 8'd2;
  localparam logic [7:0] IdxData0  = 8'd3;
  localparam logic [7:0] IdxCrcHi  = 8'(3 + BlockBytes);
  localparam logic [7:0] IdxCrcLo  = 8'(4 + BlockBytes);
  localparam logic [7:0] FillFull  = 8'(BlockBytes);

  localparam logic [15:0] CrcPoly = 16'h1021;

  // link symbols
  localparam logic [7:0] SymSoh = 8'h01;
  localparam logic [7:0] SymEot = 8'h04;
  localparam logic [7:0] SymAck = 8'h06;
  localparam logic [7:0] SymNak = 8'h15;

  // operation codes
  localparam logic [1:0] OpPeer   = 2'd0;
  localparam logic [1:0] OpData   = 2'd1;
  localparam logic [1:0] OpSrcEnd = 2'd2;
  localparam logic [1:0] OpSlot   = 2'd3;

  // configuration register indexes
  localparam logic RegRetryLimit = 1'b0;
  localparam logic RegPadValue   = 1'b1;

  localparam logic [7:0] RetryLimitRst = 8'd10;
  localparam logic [7:0] PadValueRst   = 8'h00;

  // reported phase codes
  localparam logic [3:0] PhCodeWait      = 4'd0;
  localparam logic [3:0] PhCodeLoad      = 4'd1;
  localparam logic [3:0] PhCodeSend      = 4'd2;
  localparam logic [3:0] PhCodeReply     = 4'd3;
  localparam logic [3:0] PhCodeEot       = 4'd4;
  localparam logic [3:0] PhCodeEotReply  = 4'd5;
  localparam logic [3:0] PhCodeDone      = 4'd6;
  localparam logic [3:0] PhCodeRetryFail = 4'd7;
  localparam logic [3:0] PhCodeBadReply  = 4'd8;

  typedef enum logic [8:0] {
    PH_WAIT       = 9'b000000001,
    PH_LOAD       = 9'b000000010,
    PH_SEND       = 9'b000000100,
    PH_REPLY      = 9'b000001000,
    PH_EOT        = 9'b000010000,
    PH_EOT_REPLY  = 9'b000100000,
    PH_DONE       = 9'b001000000,
    PH_RETRY_FAIL = 9'b010000000,
    PH_BAD_REPLY  = 9'b100000000
  } phase_e;

  // controller to datapath
  typedef struct packed {
    logic commit_plain;
    logic issue_fetch;
    logic commit_data;
  } xcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic data_slot;
    logic out_free;
  } xcs_sts_t;

  function automatic logic [3:0] phase_code(input phase_e ph);
    logic [3:0] code;
    unique case (ph)
      PH_WAIT:       code = PhCodeWait;
      PH_LOAD:       code = PhCodeLoad;
      PH_SEND:       code = PhCodeSend;
      PH_REPLY:      code = PhCodeReply;
      PH_EOT:        code = PhCodeEot;
      PH_EOT_REPLY:  code = PhCodeEotReply;
      PH_DONE:       code = PhCodeDone;
      PH_RETRY_FAIL: code = PhCodeRetryFail;
      PH_BAD_REPLY:  code = PhCodeBadReply;
      default:       code = PhCodeWait;
    endcase
    return code;
  endfunction

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/xcs_ram.sv =====
// ----------------------------------------------------------------------------
// xcs_ram
// generic single write port ram with a registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 128,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/xcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// xcs_ctrl
// transaction sequencer: plain items commit at once, data bytes wait in a
// fetch state for the registered block store read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xmodem_crc_block_sender_core_assert.svh"

module xcs_ctrl
  import xcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  xcs_sts_t sts_i,
  output xcs_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.commit_plain = accept && !sts_i.data_slot;
    cmd_o.issue_fetch  = accept && sts_i.data_slot;
    cmd_o.commit_data  = (state_q == ST_FETCH) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.issue_fetch) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (cmd_o.commit_data) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `XCS_ASSERT_IMP(a_fetch_stalls, clk_i, rst_ni, state_q == ST_FETCH, in_stall_o, "input taken during fetch")
  `XCS_ASSERT_NXT(a_no_accept_after_fetch, clk_i, rst_ni, cmd_o.issue_fetch, !(in_valid_i && !in_stall_o), "accept while fetch pending")
  `XCS_ASSERT_IMP(a_cmd_exclusive, clk_i, rst_ni, 1'b1, $onehot0(cmd_o), "more than one command")

endmodule

// ===== rtl/core/xcs_datapath.sv =====
// ----------------------------------------------------------------------------
// xcs_datapath
// protocol state, block store, crc accumulator, config and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xmodem_crc_block_sender_core_assert.svh"

module xcs_datapath
  import xcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic [1:0] operation_i,
  input  logic [7:0] byte_value_i,
  input  xcs_cmd_t   cmd_i,
  output xcs_sts_t   sts_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic [3:0] phase_o,
  output logic [7:0] block_number_o,
  output logic [7:0] retry_count_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  resend_q, resend_d;
  logic [7:0]  send_idx_q, send_idx_d;
  logic [7:0]  fill_q, fill_d;
  logic [15:0] crc_q, crc_d;
  logic        src_end_q, src_end_d;
  logic [7:0]  pad_lat_q, pad_lat_d;
  logic [7:0]  retry_limit_q, pad_value_q;

  logic        out_valid_q;
  logic        tx_valid_q;
  logic [7:0]  tx_byte_q, block_q, retry_q;
  logic [3:0]  phase_out_q;

  logic        tx_v;
  logic [7:0]  tx_b;
  logic        ram_we;
  logic [7:0]  data_off;
  logic [7:0]  ram_rdata;
  logic [7:0]  data_byte;
  logic        phase_early;
  logic        commit;

  assign data_off  = send_idx_q - IdxData0;
  assign data_byte = (data_off < fill_q) ? ram_rdata : pad_lat_q;
  assign commit    = cmd_i.commit_plain || cmd_i.commit_data;

  assign phase_early = (phase_q == PH_WAIT) || (phase_q == PH_LOAD) ||
                       (phase_q == PH_SEND) || (phase_q == PH_REPLY);

  always_comb begin
    sts_o.data_slot = (operation_i == OpSlot) && (phase_q == PH_SEND) &&
                      (send_idx_q >= IdxData0) && (send_idx_q < IdxCrcHi);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  xcs_ram #(
    .Width(8),
    .Depth(BlockBytes)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[StoreAw-1:0]),
    .wdata_i(byte_value_i),
    .re_i   (cmd_i.issue_fetch),
    .raddr_i(data_off[StoreAw-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    phase_d    = phase_q;
    seq_d      = seq_q;
    resend_d   = resend_q;
    send_idx_d = send_idx_q;
    fill_d     = fill_q;
    crc_d      = crc_q;
    src_end_d  = src_end_q;
    pad_lat_d  = pad_lat_q;
    tx_v       = 1'b0;
    tx_b       = 8'h00;
    ram_we     = 1'b0;
    if (cmd_i.commit_data) begin
      tx_v       = 1'b1;
      tx_b       = data_byte;
      crc_d      = crc16_byte(crc_q, data_byte);
      send_idx_d = send_idx_q + 8'd1;
    end else if (cmd_i.commit_plain) begin
      if ((operation_i == OpSrcEnd) && phase_early) begin
        src_end_d = 1'b1;
      end
      unique case (phase_q)
        PH_WAIT: begin
          if (operation_i == OpPeer) begin
            resend_d = 8'd0;
            fill_d   = 8'd0;
            phase_d  = src_end_q ? PH_EOT : PH_LOAD;
          end
        end
        PH_LOAD: begin
          if (operation_i == OpData) begin
            ram_we = 1'b1;
            fill_d = fill_q + 8'd1;
            if (fill_d == FillFull) begin
              send_idx_d = 8'd0;
              phase_d    = PH_SEND;
            end
          end else if (operation_i == OpSrcEnd) begin
            if (fill_q == 8'd0) begin
              phase_d = PH_EOT;
            end else begin
              // rest of the block reads back as the pad byte seen now
              pad_lat_d  = pad_value_q;
              send_idx_d = 8'd0;
              phase_d    = PH_SEND;
            end
          end
        end
        PH_SEND: begin
          if (operation_i == OpSlot) begin
            tx_v       = 1'b1;
            send_idx_d = send_idx_q + 8'd1;
            priority if (send_idx_q == IdxSoh) begin
              tx_b  = SymSoh;
              crc_d = 16'h0000;
            end else if (send_idx_q == IdxSeq) begin
              tx_b = seq_q;
            end else if (send_idx_q == IdxSeqInv) begin
              tx_b = ~seq_q;
            end else if (send_idx_q == IdxCrcHi) begin
              tx_b = crc_q[15:8];
            end else begin
              tx_b    = crc_q[7:0];
              phase_d = PH_REPLY;
            end
          end
        end
        PH_REPLY: begin
          if (operation_i == OpPeer) begin
            priority if (byte_value_i == SymAck) begin
              seq_d    = seq_q + 8'd1;
              resend_d = 8'd0;
              fill_d   = 8'd0;
              phase_d  = src_end_q ? PH_EOT : PH_LOAD;
            end else if (byte_value_i == SymNak) begin
              if (resend_q > retry_limit_q) begin
                phase_d = PH_RETRY_FAIL;
              end else begin
                if (resend_q != 8'hFF) begin
                  resend_d = resend_q + 8'd1;
                end
                send_idx_d = 8'd0;
                phase_d    = PH_SEND;
              end
            end else begin
              phase_d = PH_BAD_REPLY;
            end
          end
        end
        PH_EOT: begin
          if (operation_i == OpSlot) begin
            tx_v    = 1'b1;
            tx_b    = SymEot;
            phase_d = PH_EOT_REPLY;
          end
        end
        PH_EOT_REPLY: begin
          if (operation_i == OpPeer) begin
            phase_d = (byte_value_i == SymAck) ? PH_DONE : PH_EOT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_WAIT;
      seq_q         <= 8'd1;
      resend_q      <= 8'd0;
      send_idx_q    <= 8'd0;
      fill_q        <= 8'd0;
      crc_q         <= 16'h0000;
      src_end_q     <= 1'b0;
      retry_limit_q <= RetryLimitRst;
      pad_value_q   <= PadValueRst;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      seq_q      <= seq_d;
      resend_q   <= resend_d;
      send_idx_q <= send_idx_d;
      fill_q     <= fill_d;
      crc_q      <= crc_d;
      src_end_q  <= src_end_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegRetryLimit: retry_limit_q <= cfg_wdata_i;
          RegPadValue:   pad_value_q   <= cfg_wdata_i;
          default:       retry_limit_q <= retry_limit_q;
        endcase
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pad_lat_q <= pad_lat_d;
    if (commit) begin
      tx_valid_q  <= tx_v;
      tx_byte_q   <= tx_b;
      phase_out_q <= phase_code(phase_d);
      block_q     <= seq_d;
      retry_q     <= resend_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_valid_o     = tx_valid_q;
  assign tx_byte_o      = tx_byte_q;
  assign phase_o        = phase_out_q;
  assign block_number_o = block_q;
  assign retry_count_o  = retry_q;

  `XCS_ASSERT_IMP(a_data_only_in_send, clk_i, rst_ni, cmd_i.commit_data, phase_q == PH_SEND, "data byte outside send phase")
  `XCS_ASSERT_IMP(a_send_idx_range, clk_i, rst_ni, phase_q == PH_SEND, send_idx_q <= IdxCrcLo, "send index past frame end")
  `XCS_ASSERT_IMP(a_fill_range, clk_i, rst_ni, phase_q == PH_LOAD, fill_q < FillFull, "fill count past block in load")

endmodule

// ===== rtl/core/xmodem_crc_block_sender_core.sv =====
// ----------------------------------------------------------------------------
// xmodem_crc_block_sender_core
// xmodem-crc sender: 128-byte blocks, crc-16 trailer, nak resends, eot close
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o    | operation_i, byte_value_i
//   out     | output    | out_valid_o / out_stall_i  | tx_valid_o, tx_byte_o,
//           |           |                            | phase_o, block_number_o,
//           |           |                            | retry_count_o
//   cfg     | input     | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// every input transaction gives exactly one output transaction
// most transactions commit when taken; a frame data byte waits in a fetch
// state, since the block store read is registered and the crc step follows it
// a new input is taken while a result waits, as long as the result register
// drains in the same cycle
// reset is asynchronous; the block store needs no clearing pass, every entry
// sent is first written by data or covered by the latched pad byte
// out_stall_i held high stalls the input side once the result register is full
//
`timescale 1ns / 1ps

module xmodem_crc_block_sender_core
  import xcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  // input transactions
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] byte_value_i,
  // output transactions
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic [3:0] phase_o,
  output logic [7:0] block_number_o,
  output logic [7:0] retry_count_o
);

  // command and status between sequencer and datapath
  xcs_cmd_t cmd;
  xcs_sts_t sts;

  // sequencer: decides when a transaction commits and when the store is read
  xcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: protocol phase, counters, crc, block store and result register
  xcs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .byte_value_i  (byte_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .phase_o       (phase_o),
    .block_number_o(block_number_o),
    .retry_count_o (retry_count_o)
  );

endmodule

// ===== tb/sv/xmodem_crc_block_sender_core_tb.sv =====
// ----------------------------------------------------------------------------
// xmodem_crc_block_sender_core_tb
// self-checking bench for the xmodem-crc block sender core: a planner builds
// mostly well-formed transfers with random content and ignored noise events,
// a clocked driver offers them, and a clocked monitor predicts each result
// and compares it field by field with what the core reports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmodem_crc_block_sender_core_tb;
  import xcs_pkg::*;

  localparam int HoldCycles   = 400;   // long receiver hold-off, fills the core
  localparam int IdleLimit    = 5000;  // cycles with no transaction before giving up
  localparam int SettleCycles = 20;    // quiet time after the last result

  // one event offered to the core
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] val;
  } link_event_t;

  // one status report, fields in port order
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] phase;
    logic [7:0] block_number;
    logic [7:0] retry_count;
  } link_report_t;

  // sender protocol state
  typedef struct packed {
    logic [3:0]                 ph;
    logic [BlockBytes-1:0][7:0] store;
    logic [7:0]                 fill;
    logic [7:0]                 idx;
    logic [15:0]                crc;
    logic [7:0]                 seq;
    logic [7:0]                 resends;
    logic                       ended;
  } sender_t;

  typedef enum int {FIN_DONE, FIN_RETRY_FAIL, FIN_BAD_REPLY} finish_kind_e;

  // dut connections, the driven inputs all known from time zero
  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_we       = 1'b0;
  logic       cfg_index    = RegRetryLimit;
  logic [7:0] cfg_wdata    = 8'h00;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [1:0] operation    = OpPeer;
  logic [7:0] byte_value   = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [3:0] phase;
  logic [7:0] block_number;
  logic [7:0] retry_count;

  // register copies seen by the predictor
  logic [7:0] retry_limit_q = RetryLimitRst;
  logic [7:0] pad_q         = PadValueRst;

  sender_t      plan;           // planner copy, runs ahead of the core
  sender_t      chk;            // checker copy, advanced on accepted transactions
  link_event_t  event_q[$];     // events waiting for the driver
  link_report_t report_q[$];    // predicted reports waiting for the core

  int  issued        = 0;
  int  accepted      = 0;
  int  send_gap_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_ask      = 0;
  int  fault_count   = 0;
  int  results_seen  = 0;
  int  link_bytes    = 0;
  bit  in_taken      = 1'b0;
  bit  wrap_up       = 1'b0;
  bit  cut_source    = 1'b0;
  int  end_fill      = -1;
  finish_kind_e finish_kind = FIN_DONE;
  logic [3:0] last_phase = PhCodeWait;
  logic [7:0] last_block = 8'd1;

  xmodem_crc_block_sender_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .byte_value_i   (byte_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tx_valid_o     (tx_valid),
    .tx_byte_o      (tx_byte),
    .phase_o        (phase),
    .block_number_o (block_number),
    .retry_count_o  (retry_count)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // crc-16, poly 0x1021, bit-serial msb first
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    int   i;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic sender_t fresh_state();
    sender_t s;
    s     = '0;
    s.ph  = PhCodeWait;
    s.seq = 8'd1;
    return s;
  endfunction

  // one event in, one report out; s carries the protocol state
  function automatic link_report_t advance_sender(inout sender_t s, input logic [1:0] op,
                                                  input logic [7:0] b);
    link_report_t r;
    int           k;
    r = '0;
    // a source end is remembered until the exchange is over
    if (op == OpSrcEnd && s.ph <= PhCodeReply) s.ended = 1'b1;
    case (s.ph)
      PhCodeWait: begin
        if (op == OpPeer) begin
          s.resends = 8'd0;
          s.fill    = 8'd0;
          s.ph      = s.ended ? PhCodeEot : PhCodeLoad;
        end
      end
      PhCodeLoad: begin
        if (op == OpData) begin
          s.store[s.fill[6:0]] = b;
          s.fill = s.fill + 8'd1;
          if (s.fill == FillFull) begin
            s.idx = IdxSoh;
            s.ph  = PhCodeSend;
          end
        end else if (op == OpSrcEnd) begin
          if (s.fill == 8'd0) begin
            // nothing loaded, close the transfer
            s.ph = PhCodeEot;
          end else begin
            // short final block, pad the tail
            for (k = 0; k < BlockBytes; k++) begin
              if (k >= int'(s.fill)) s.store[k] = pad_q;
            end
            s.fill = FillFull;
            s.idx  = IdxSoh;
            s.ph   = PhCodeSend;
          end
        end
      end
      PhCodeSend: begin
        if (op == OpSlot) begin
          r.tx_valid = 1'b1;
          if (s.idx == IdxSoh) begin
            r.tx_byte = SymSoh;
            s.crc     = 16'h0000;
          end else if (s.idx == IdxSeq) begin
            r.tx_byte = s.seq;
          end else if (s.idx == IdxSeqInv) begin
            r.tx_byte = ~s.seq;
          end else if (s.idx < IdxCrcHi) begin
            r.tx_byte = s.store[7'(s.idx - IdxData0)];
            s.crc     = crc16_next(s.crc, r.tx_byte);
          end else if (s.idx == IdxCrcHi) begin
            r.tx_byte = s.crc[15:8];
          end else begin
            r.tx_byte = s.crc[7:0];
            s.ph      = PhCodeReply;
          end
          s.idx = s.idx + 8'd1;
        end
      end
      PhCodeReply: begin
        if (op == OpPeer) begin
          if (b == SymAck) begin
            s.seq     = s.seq + 8'd1;
            s.resends = 8'd0;
            s.fill    = 8'd0;
            s.ph      = s.ended ? PhCodeEot : PhCodeLoad;
          end else if (b == SymNak) begin
            if (s.resends > retry_limit_q) begin
              s.ph = PhCodeRetryFail;
            end else begin
              // saturates, so a limit of 255 resends forever
              if (s.resends != 8'hFF) s.resends = s.resends + 8'd1;
              s.idx = IdxSoh;
              s.ph  = PhCodeSend;
            end
          end else begin
            s.ph = PhCodeBadReply;
          end
        end
      end
      PhCodeEot: begin
        if (op == OpSlot) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = SymEot;
          s.ph       = PhCodeEotReply;
        end
      end
      PhCodeEotReply: begin
        if (op == OpPeer) s.ph = (b == SymAck) ? PhCodeDone : PhCodeEot;
      end
      default: begin
        // done, retry fail and bad reply hold until reset
      end
    endcase
    r.phase        = s.ph;
    r.block_number = s.seq;
    r.retry_count  = s.resends;
    return r;
  endfunction

  // queue one event and advance the planner; ignored events are not counted
  task automatic offer(input logic [1:0] op, input logic [7:0] b, inout int counted);
    sender_t      prior;
    link_report_t r;
    link_event_t  ev;
    prior  = plan;
    r      = advance_sender(plan, op, b);
    if (r.tx_valid || plan != prior) counted++;
    ev.op  = op;
    ev.val = b;
    event_q.push_back(ev);
    issued++;
  endtask

  // pick the next event from the planner phase, now and then an ignored one
  task automatic plan_next(inout int counted);
    logic [1:0] op;
    logic [1:0] keep;
    logic [7:0] b;
    bit         noise;
    noise = ($urandom_range(0, 9) == 0);
    b     = 8'($urandom);
    op    = OpPeer;
    case (plan.ph)
      PhCodeWait: op = OpPeer;
      PhCodeLoad: begin
        if (cut_source && !plan.ended && end_fill == int'(plan.fill)) op = OpSrcEnd;
        else op = OpData;
      end
      PhCodeSend: begin
        if (cut_source && !plan.ended && end_fill < 0 && $urandom_range(0, 19) == 0)
          op = OpSrcEnd;
        else op = OpSlot;
      end
      PhCodeReply: begin
        if (cut_source && !plan.ended && end_fill < 0 && $urandom_range(0, 2) == 0) begin
          op = OpSrcEnd;
        end else begin
          op = OpPeer;
          if (wrap_up && finish_kind == FIN_RETRY_FAIL) begin
            b = SymNak;
          end else if (wrap_up && finish_kind == FIN_BAD_REPLY) begin
            while (b == SymAck || b == SymNak) b = 8'($urandom);
          end else if (plan.resends <= retry_limit_q && $urandom_range(0, 5) == 0) begin
            b = SymNak;
          end else begin
            b = SymAck;
          end
        end
      end
      PhCodeEot: op = OpSlot;
      PhCodeEotReply: begin
        op = OpPeer;
        if ($urandom_range(0, 2) != 0) b = SymAck;
      end
      default: op = 2'($urandom);
    endcase
    // noise: an operation the current phase ignores, never a source end before the eot phases
    if (noise && op != OpSrcEnd) begin
      keep = op;
      do op = 2'($urandom);
      while (op == keep || (op == OpSrcEnd && plan.ph <= PhCodeReply));
    end
    offer(op, b, counted);
  endtask

  task automatic emit_items(input int n);
    int counted;
    counted = 0;
    while (counted < n && plan.ph < PhCodeDone) plan_next(counted);
  endtask

  // all offered events taken and every predicted report seen
  task automatic wait_idle();
    while (accepted != issued || report_q.size() != 0) @(negedge clk);
  endtask

  // write both registers on back-to-back edges, core idle
  task automatic set_regs(input logic [7:0] lim, input logic [7:0] pad);
    cfg_we    <= 1'b1;
    cfg_index <= RegRetryLimit;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_index <= RegPadValue;
    cfg_wdata <= pad;
    @(negedge clk);
    cfg_we    <= 1'b0;
    retry_limit_q = lim;
    pad_q         = pad;
  endtask

  // driver: a new event once the current one is taken, random gaps
  always @(negedge clk) begin : drive_events
    link_event_t ev;
    if (!in_valid || in_taken) begin
      if (event_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        ev = event_q.pop_front();
        operation  <= ev.op;
        byte_value <= ev.val;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : drive_stall
    int hold_left;
    int hold_seen;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor: predict on accepted input, compare on accepted output, watchdog
  always @(posedge clk) begin : watch_link
    link_report_t want;
    int           idle_cycles;
    bit           out_taken;
    if (rst_n) begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      // prediction first so a same-edge result still finds its expectation
      if (in_taken) begin
        report_q.push_back(advance_sender(chk, operation, byte_value));
        accepted++;
      end
      if (out_taken) begin
        results_seen++;
        if (report_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          fault_count++;
        end else begin
          want = report_q.pop_front();
          if (tx_valid !== want.tx_valid) begin
            $error("tx_valid: expected %0h, got %0h", want.tx_valid, tx_valid);
            fault_count++;
          end
          if (tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte);
            fault_count++;
          end
          if (phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, phase);
            fault_count++;
          end
          if (block_number !== want.block_number) begin
            $error("block_number: expected %0d, got %0d", want.block_number, block_number);
            fault_count++;
          end
          if (retry_count !== want.retry_count) begin
            $error("retry_count: expected %0d, got %0d", want.retry_count, retry_count);
            fault_count++;
          end
          if (want.tx_valid) link_bytes++;
          last_phase = want.phase;
          last_block = want.block_number;
        end
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         dummy;
    int         k;
    logic [7:0] mid_limit;
    logic [7:0] final_limit;
    logic [7:0] final_pad;
    dummy = 0;
    plan  = fresh_state();
    chk   = fresh_state();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes first: resends never run out, all-ones fill byte
    set_regs(8'd255, 8'hFF);

    // directed: ignored operations while waiting, then a start byte
    offer(OpData, 8'h00, dummy);
    offer(OpData, 8'hFF, dummy);
    offer(OpSlot, 8'h5A, dummy);
    offer(OpPeer, 8'h43, dummy);
    // load phase ignores peer bytes and transmit slots
    offer(OpPeer, SymNak, dummy);
    offer(OpSlot, 8'hFF, dummy);
    // data byte extremes at the head of block one
    offer(OpData, 8'h00, dummy);
    offer(OpData, 8'hFF, dummy);
    offer(OpData, 8'h80, dummy);
    offer(OpData, 8'h7F, dummy);
    offer(OpData, 8'h01, dummy);
    offer(OpData, 8'hFE, dummy);

    // sender mostly busy, receiver mostly stalled
    send_gap_pct   = 8;
    recv_stall_pct = 75;
    emit_items(500);
    wait_idle();

    // receiver holds off while the sender keeps offering
    set_regs(8'd0, 8'h00);
    send_gap_pct = 0;
    hold_ask++;
    emit_items(200);
    wait_idle();

    // sender mostly idle, receiver mostly ready
    mid_limit = 8'($urandom_range(1, 254));
    set_regs(mid_limit, 8'($urandom));
    send_gap_pct   = 75;
    recv_stall_pct = 8;
    emit_items(500);
    wait_idle();

    // no idling from here on
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    emit_items(300);
    wait_idle();

    // wind down into one of the terminal phases
    case ($urandom_range(0, 3))
      0:       finish_kind = FIN_RETRY_FAIL;
      1:       finish_kind = FIN_BAD_REPLY;
      default: finish_kind = FIN_DONE;
    endcase
    final_limit = (finish_kind == FIN_RETRY_FAIL) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(1, 254));
    final_pad = ($urandom_range(0, 2) == 0) ? 8'h00
              : (($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom));
    set_regs(final_limit, final_pad);
    // source cut in a partial block, on an empty block, or mid exchange
    end_fill   = ($urandom_range(0, 3) == 0) ? -1
               : (($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, BlockBytes - 1)));
    cut_source = (finish_kind == FIN_DONE);
    wrap_up    = 1'b1;
    emit_items(100000);
    // terminal phase ignores everything
    for (k = 0; k < 12; k++) offer(2'($urandom), 8'($urandom), dummy);
    wait_idle();

    repeat (SettleCycles) @(negedge clk);
    $display("covered %0d result transactions, %0d bytes to the peer, last block %0d",
             results_seen, link_bytes, last_block);
    $display("retry limits 255, 0, %0d and %0d; transfer closed in phase %0d",
             mid_limit, final_limit, last_phase);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
